@@ rtl/ddo_pkg.sv @@
`default_nettype none

package ddo_pkg;

    // Fixed field widths
    localparam int CNT_W  = 32;
    localparam int ACC_W  = 48;
    localparam int ACC_W1 = ACC_W + 1;
    localparam int DIAM_W = 8;
    localparam int TREAD_W = 9;
    localparam int DEG_W  = 9;
    localparam int STEP_W = 5;

    // Default parameter values
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    // Shared multiplier geometry
    localparam int MUL_W      = 64;
    localparam int DIG_W      = 16;
    localparam int MUL_DIGITS = MUL_W / DIG_W;
    localparam int DCNT_W     = $clog2(MUL_DIGITS);

    // Arithmetic constants
    localparam logic [63:0] PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] TRAVEL_K = PI_Q60 / 64'd360;
    localparam logic [30:0] GAIN_Q30 = 31'd652032874;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [DEG_W-1:0] DEG_TURN = 9'd360;
    localparam logic [DEG_W-1:0] DEG_HALF = 9'd180;

    // Configuration register indexes
    localparam logic REG_DIAMETER = 1'b0;
    localparam logic REG_TREAD    = 1'b1;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_RESET  = 2'd1,
        FUNC_ARM    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MSEL_TL,
        MSEL_TR,
        MSEL_PX,
        MSEL_PY
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MISC,
        ST_TL_START,
        ST_TL_WAIT,
        ST_TR_START,
        ST_TR_WAIT,
        ST_MEAN,
        ST_VEC,
        ST_ROT_INIT,
        ST_ROT,
        ST_PX_START,
        ST_PX_WAIT,
        ST_PY_START,
        ST_PY_WAIT,
        ST_WRITE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              misc;
        logic              mul_start;
        mul_sel_t          mul_sel;
        logic              cap_tl;
        logic              cap_tr;
        logic              upd_mean;
        logic              vec_step;
        logic              rot_init;
        logic              rot_step;
        logic              cap_px;
        logic              cap_py;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       mul_done;
    } sts_t;

    // Arctangent table, 2^32 units per turn
    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ddo_mul.sv @@
`default_nettype none

// 64x64 unsigned multiplier, one 16-bit digit of a per cycle
module ddo_mul
    import ddo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MUL_W-1:0]     a,
    input  wire logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]        prod,
    output logic                      done
);

    logic [MUL_W-1:0]       a_reg, b_reg;
    logic [2*MUL_W-1:0]     acc_reg, acc_next;
    logic [DIG_W+MUL_W-1:0] pp;
    logic [DCNT_W-1:0]      cnt_reg;
    logic                   busy_reg, done_reg;

    // partial product lands at the top, earlier ones shift down
    assign pp = (DIG_W+MUL_W)'(a_reg[DIG_W-1:0]) * (DIG_W+MUL_W)'(b_reg);
    assign acc_next = (acc_reg >> DIG_W) + {pp, {(MUL_W-DIG_W){1'b0}}};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(MUL_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg >> DIG_W;
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/ddo_ctrl.sv @@
`default_nettype none

// Request sequencer
module ddo_ctrl
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_step, out_free, accept;

    assign last_step = (cnt_reg == STEP_W'(CORDIC_STEPS - 1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign accept    = in_valid && (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: state_next = (sts.func == FUNC_SAMPLE) ? ST_TL_START : ST_MISC;
            ST_MISC:     state_next = ST_WRITE;
            ST_TL_START: state_next = ST_TL_WAIT;
            ST_TL_WAIT:  if (sts.mul_done) state_next = ST_TR_START;
            ST_TR_START: state_next = ST_TR_WAIT;
            ST_TR_WAIT:  if (sts.mul_done) state_next = ST_MEAN;
            ST_MEAN:     state_next = ST_VEC;
            ST_VEC:      if (last_step) state_next = ST_ROT_INIT;
            ST_ROT_INIT: state_next = ST_ROT;
            ST_ROT:      if (last_step) state_next = ST_PX_START;
            ST_PX_START: state_next = ST_PX_WAIT;
            ST_PX_WAIT:  if (sts.mul_done) state_next = ST_PY_START;
            ST_PY_START: state_next = ST_PY_WAIT;
            ST_PY_WAIT:  if (sts.mul_done) state_next = ST_WRITE;
            ST_WRITE:    if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // step counter for the CORDIC passes
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == ST_VEC || state_reg == ST_ROT)
            cnt_next = last_step ? '0 : cnt_reg + 1'b1;
        else
            cnt_next = '0;
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MSEL_TL;
        cmd.step     = cnt_reg;
        cmd.latch    = accept;
        unique case (state_reg)
            ST_MISC:     cmd.misc = 1'b1;
            ST_TL_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_TL;
            end
            ST_TL_WAIT:  cmd.cap_tl = sts.mul_done;
            ST_TR_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_TR;
            end
            ST_TR_WAIT:  cmd.cap_tr = sts.mul_done;
            ST_MEAN:     cmd.upd_mean = 1'b1;
            ST_VEC:      cmd.vec_step = 1'b1;
            ST_ROT_INIT: cmd.rot_init = 1'b1;
            ST_ROT:      cmd.rot_step = 1'b1;
            ST_PX_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_PX;
            end
            ST_PX_WAIT:  cmd.cap_px = sts.mul_done;
            ST_PY_START:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_PY;
            end
            ST_PY_WAIT:  cmd.cap_py = sts.mul_done;
            ST_WRITE:    cmd.out_load = out_free;
            default:     ;
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/ddo_datapath.sv @@
`default_nettype none

// Odometry datapath: pose state, CORDIC iterator, shared multiplier
module ddo_datapath
    import ddo_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output sts_t                          sts,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [TREAD_W-1:0]       cfg_data,
    input  wire logic [1:0]               func,
    input  wire logic signed [CNT_W-1:0]  left_count,
    input  wire logic signed [CNT_W-1:0]  right_count,
    input  wire logic signed [CNT_W-1:0]  notify_delta_mm,
    output logic signed [CNT_W-1:0]       distance_mm,
    output logic [DEG_W-1:0]              azimuth_deg,
    output logic signed [DEG_W-1:0]       heading_deg,
    output logic signed [CNT_W-1:0]       loc_x_mm,
    output logic signed [CNT_W-1:0]       loc_y_mm,
    output logic                          dist_reached
);

    localparam int TRV_W = FRAC_BITS + 35;
    localparam int SUM_W = ((TRV_W > ACC_W) ? TRV_W : ACC_W) + 2;
    localparam int CW    = TRV_W + 3;
    localparam int SH_T  = 60 - FRAC_BITS;
    localparam int SH_P  = 30;
    localparam logic signed [ACC_W1-1:0] RND_MM = ACC_W1'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [ACC_W1-1:0] MM_MAX = ACC_W1'(33'sh0_7FFF_FFFF);
    localparam logic signed [ACC_W1-1:0] MM_MIN = ACC_W1'(33'sh1_8000_0000);

    // saturate to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi, lo;
        hi = SUM_W'(ACC_MAX);
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return hi[ACC_W-1:0];
        else if (v < lo)
            return lo[ACC_W-1:0];
        else
            return v[ACC_W-1:0];
    endfunction

    // truncate toward zero to whole mm, saturate to 32 bits
    function automatic logic signed [CNT_W-1:0] to_mm(input logic signed [ACC_W-1:0] q);
        logic signed [ACC_W1-1:0] adj, v;
        adj = ACC_W1'(q) + (q[ACC_W-1] ? RND_MM : '0);
        v   = adj >>> FRAC_BITS;
        if (v > MM_MAX)
            return MM_MAX[CNT_W-1:0];
        else if (v < MM_MIN)
            return MM_MIN[CNT_W-1:0];
        else
            return v[CNT_W-1:0];
    endfunction

    // configuration
    logic [DIAM_W-1:0]  diam_reg;
    logic [TREAD_W-1:0] tread_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diam_reg  <= DIAM_W'(100);
            tread_reg <= TREAD_W'(150);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_DIAMETER)
                diam_reg <= cfg_data[DIAM_W-1:0];
            else if (cfg_index == REG_TREAD)
                tread_reg <= cfg_data;
        end
    end

    // request capture
    logic [1:0]              func_reg;
    logic signed [CNT_W-1:0] left_reg, right_reg, ndelta_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg   <= func;
            left_reg   <= left_count;
            right_reg  <= right_count;
            ndelta_reg <= notify_delta_mm;
        end
    end

    // state
    logic signed [CNT_W-1:0] prev_left_reg, prev_right_reg;
    logic signed [ACC_W-1:0] travel_reg, pos_x_reg, pos_y_reg, target_reg;
    logic [31:0]             heading_reg;
    logic                    reached_reg;

    // working registers
    logic signed [TRV_W-1:0] tl_reg, tr_reg, mean_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg;
    logic signed [33:0]      cz_reg;
    logic                    yzero_reg, flip_reg;

    // count deltas and wheel travel operands
    logic signed [CNT_W:0] dl, dr;
    logic [CNT_W:0]        dl_mag, dr_mag;
    logic [40:0]           ml, mr;

    assign dl     = (CNT_W+1)'(left_reg) - (CNT_W+1)'(prev_left_reg);
    assign dr     = (CNT_W+1)'(right_reg) - (CNT_W+1)'(prev_right_reg);
    assign dl_mag = dl[CNT_W] ? (~dl + 1'b1) : dl;
    assign dr_mag = dr[CNT_W] ? (~dr + 1'b1) : dr;
    assign ml     = 41'(diam_reg) * 41'(dl_mag);
    assign mr     = 41'(diam_reg) * 41'(dr_mag);

    // sin and cos from the rotation result
    logic signed [CW-1:0] s_val, c_val;
    logic [CW-1:0]        s_mag, c_mag;
    logic [TRV_W-1:0]     mean_mag;

    assign s_val    = flip_reg ? -cy_reg : cy_reg;
    assign c_val    = flip_reg ? -cx_reg : cx_reg;
    assign s_mag    = s_val[CW-1] ? (~s_val + 1'b1) : s_val;
    assign c_mag    = c_val[CW-1] ? (~c_val + 1'b1) : c_val;
    assign mean_mag = mean_reg[TRV_W-1] ? (~mean_reg + 1'b1) : mean_reg;

    // multiplier operand select
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;
    logic               mul_done;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MSEL_TL:
            begin
                mul_a = MUL_W'(ml);
                mul_b = TRAVEL_K;
            end
            MSEL_TR:
            begin
                mul_a = MUL_W'(mr);
                mul_b = TRAVEL_K;
            end
            MSEL_PX:
            begin
                mul_a = MUL_W'(mean_mag);
                mul_b = MUL_W'(s_mag);
            end
            default:
            begin
                mul_a = MUL_W'(mean_mag);
                mul_b = MUL_W'(c_mag);
            end
        endcase
    end

    ddo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    // rounding of the product
    logic [2*MUL_W-1:0]      rnd_t, rnd_p;
    logic [TRV_W-1:0]        trv_mag, term_mag;
    logic signed [TRV_W-1:0] trv_l, trv_r;
    logic signed [TRV_W:0]   term_x, term_y;

    assign rnd_t    = prod + ((2*MUL_W)'(1) << (SH_T - 1));
    assign rnd_p    = prod + ((2*MUL_W)'(1) << (SH_P - 1));
    assign trv_mag  = rnd_t[SH_T +: TRV_W];
    assign term_mag = rnd_p[SH_P +: TRV_W];
    assign trv_l    = dl[CNT_W] ? -$signed(trv_mag) : $signed(trv_mag);
    assign trv_r    = dr[CNT_W] ? -$signed(trv_mag) : $signed(trv_mag);
    assign term_x   = (mean_reg[TRV_W-1] ^ s_val[CW-1]) ? -$signed({1'b0, term_mag})
                                                        : $signed({1'b0, term_mag});
    assign term_y   = (mean_reg[TRV_W-1] ^ c_val[CW-1]) ? -$signed({1'b0, term_mag})
                                                        : $signed({1'b0, term_mag});

    // mean travel, truncated toward zero
    logic signed [TRV_W:0] tsum, mean_full;
    logic signed [TRV_W:0] ydiff;

    assign tsum      = (TRV_W+1)'(tl_reg) + (TRV_W+1)'(tr_reg);
    assign mean_full = $signed(tsum + (TRV_W+1)'(tsum[TRV_W])) >>> 1;
    assign ydiff     = (TRV_W+1)'(tl_reg) - (TRV_W+1)'(tr_reg);

    // accumulator updates
    logic signed [SUM_W-1:0] travel_sum, px_sum, py_sum, target_sum;

    assign travel_sum = SUM_W'(travel_reg) + SUM_W'(mean_full);
    assign px_sum     = SUM_W'(pos_x_reg) + SUM_W'(term_x);
    assign py_sum     = SUM_W'(pos_y_reg) + SUM_W'(term_y);
    assign target_sum = (SUM_W'(ndelta_reg) <<< FRAC_BITS) + SUM_W'(travel_reg);

    // heading update and rotation start angle
    logic [31:0] h_new, h_rot;
    logic        h_flip;

    assign h_new  = heading_reg + (yzero_reg ? 32'd0 : cz_reg[31:0]);
    assign h_flip = (h_new - 32'h4000_0000) < 32'h8000_0000;
    assign h_rot  = h_flip ? h_new + 32'h8000_0000 : h_new;

    // one CORDIC micro-rotation
    logic signed [CW-1:0] xs, ys;
    logic [33:0]          at;
    logic                 pos_dir;

    assign xs      = cx_reg >>> cmd.step;
    assign ys      = cy_reg >>> cmd.step;
    assign at      = 34'(atan_entry(cmd.step));
    assign pos_dir = cmd.vec_step ? ~cy_reg[CW-1] : cz_reg[33];

    always_ff @(posedge clk)
    begin
        if (cmd.cap_tl)
            tl_reg <= trv_l;
        if (cmd.cap_tr)
            tr_reg <= trv_r;
        if (cmd.upd_mean)
        begin
            mean_reg  <= mean_full[TRV_W-1:0];
            yzero_reg <= (tl_reg == tr_reg);
            cx_reg    <= $signed(CW'(tread_reg) << FRAC_BITS);
            cy_reg    <= CW'(ydiff);
            cz_reg    <= '0;
        end
        else if (cmd.rot_init)
        begin
            flip_reg <= h_flip;
            cx_reg   <= $signed(CW'(GAIN_Q30));
            cy_reg   <= '0;
            cz_reg   <= 34'($signed(h_rot));
        end
        else if (cmd.vec_step || cmd.rot_step)
        begin
            if (pos_dir)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed(at);
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed(at);
            end
        end
    end

    // pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            travel_reg     <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            target_reg     <= '0;
            heading_reg    <= '0;
            reached_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
                reached_reg <= 1'b0;
            if (cmd.misc)
            begin
                unique case (func_reg)
                    FUNC_RESET:
                    begin
                        travel_reg     <= '0;
                        pos_x_reg      <= '0;
                        pos_y_reg      <= '0;
                        heading_reg    <= '0;
                        prev_left_reg  <= left_reg;
                        prev_right_reg <= right_reg;
                    end
                    FUNC_ARM:
                        target_reg <= sat_acc(target_sum);
                    default: ;
                endcase
            end
            if (cmd.upd_mean)
            begin
                travel_reg     <= sat_acc(travel_sum);
                prev_left_reg  <= left_reg;
                prev_right_reg <= right_reg;
            end
            if (cmd.rot_init)
                heading_reg <= h_new;
            if (cmd.cap_px)
                pos_x_reg <= sat_acc(px_sum);
            // target check on the last step of a sample
            if (cmd.cap_py)
            begin
                pos_y_reg <= sat_acc(py_sum);
                if (target_reg != '0 && travel_reg > target_reg)
                begin
                    target_reg  <= '0;
                    reached_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    logic [40:0]      az_prod;
    logic [DEG_W-1:0] az;

    assign az_prod = 41'(heading_reg) * 41'(DEG_TURN);
    assign az      = az_prod[40:32];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            distance_mm  <= to_mm(travel_reg);
            azimuth_deg  <= az;
            heading_deg  <= (az > DEG_HALF) ? $signed(az - DEG_TURN) : $signed(az);
            loc_x_mm     <= to_mm(pos_x_reg);
            loc_y_mm     <= to_mm(pos_y_reg);
            dist_reached <= reached_reg;
        end
    end

    assign sts.func     = func_reg;
    assign sts.mul_done = mul_done;

endmodule

`default_nettype wire

@@ rtl/differential_drive_odometry_core.sv @@
// Sequence: an encoder sample runs from acceptance to its result through the two CORDIC
// passes and four multiplies (start, digit cycles, done); reset, arm and unused requests
// go through dispatch, a misc step and the result write.
// Flow: one request at a time; the next is taken in the cycle after the result is in
// the output register, which holds while out_stall is high.
// Reset: rst_n is asynchronous, clears pose, baseline and target, loads default wheel sizes.
`default_nettype none

module differential_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [TREAD_W-1:0]       cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               func,
    input  wire logic signed [CNT_W-1:0]  left_count,
    input  wire logic signed [CNT_W-1:0]  right_count,
    input  wire logic signed [CNT_W-1:0]  notify_delta_mm,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [CNT_W-1:0]       distance_mm,
    output logic [DEG_W-1:0]              azimuth_deg,
    output logic signed [DEG_W-1:0]       heading_deg,
    output logic signed [CNT_W-1:0]       loc_x_mm,
    output logic signed [CNT_W-1:0]       loc_y_mm,
    output logic                          dist_reached
);

    cmd_t cmd;
    sts_t sts;

    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ddo_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .left_count      (left_count),
        .right_count     (right_count),
        .notify_delta_mm (notify_delta_mm),
        .distance_mm     (distance_mm),
        .azimuth_deg     (azimuth_deg),
        .heading_deg     (heading_deg),
        .loc_x_mm        (loc_x_mm),
        .loc_y_mm        (loc_y_mm),
        .dist_reached    (dist_reached)
    );

endmodule

`default_nettype wire
